@@ sv/dpd_pkg.sv @@
// Shared types, constants and helpers of the debug packet deframer.
package dpd_pkg;

   localparam int MAX_PAYLOAD_DEF = 63;

   localparam logic [7:0] CHAR_START   = 8'h24;
   localparam logic [7:0] CHAR_END     = 8'h23;
   localparam logic [7:0] CHAR_CONSOLE = 8'h4f;
   localparam logic [7:0] CHAR_ACK     = 8'h2b;

   typedef enum logic [1:0] {
      KIND_ACK      = 2'd0,
      KIND_DATA     = 2'd1,
      KIND_EMPTY    = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_BODY = 2'd1,
      PH_SUM1 = 2'd2,
      PH_SUM2 = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      MODE_ACK_ONLY = 2'd0,
      MODE_DATA     = 2'd1,
      MODE_EMPTY    = 2'd2,
      MODE_OVERFLOW = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      BK_IDLE = 3'd0,
      BK_ACK  = 3'd1,
      BK_READ = 3'd2,
      BK_DATA = 3'd3,
      BK_TAIL = 3'd4
   } back_state_type;

   typedef struct packed {
      mode_type mode;
      logic     ack;
      logic     bank;
   } cmd_type;

   function automatic logic is_hex(input logic [7:0] b);
      is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
               (b >= 8'h41 && b <= 8'h46);
   endfunction

endpackage

@@ sv/dpd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/dpd_cmd_queue.sv @@
// Two-entry command queue between the framing front end and the result back end.
module dpd_cmd_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];
   assign full      = count_ff == 2'd2;
   assign empty     = count_ff == 2'd0;

`ifndef SYNTH
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("push into a full command queue");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from an empty command queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("command queue count out of range");
`endif

endmodule

@@ sv/dpd_front.sv @@
// Framing front end: hunts for packets, stores payload, classifies completed packets.
module dpd_front import dpd_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   localparam int CNTW = $clog2(MAX_PAYLOAD + 1),
   localparam int IDXW = $clog2(MAX_PAYLOAD)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_rx_byte,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data,
   input  logic            q_full,
   output logic            q_push,
   output cmd_type         q_cmd,
   output logic [CNTW-1:0] q_count,
   output logic            ram_wr_en,
   output logic [IDXW:0]   ram_wr_addr,
   output logic [7:0]      ram_wr_data
);

   phase_type       phase_ff, phase_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            tail_hex_ff, tail_hex_in;
   logic            first_o_ff, first_o_in;
   logic            bank_ff, bank_in;
   logic            ack_en_ff;
   logic            accept;
   logic            at_max;
   logic            is_console;

   assign req_ready  = !q_full;
   assign accept     = req_valid && req_ready;
   assign at_max     = count_ff == CNTW'(MAX_PAYLOAD);
   assign is_console = (count_ff > CNTW'(1)) && first_o_ff && tail_hex_ff;

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == CHAR_START) begin
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               if (req_rx_byte == CHAR_END) begin
                  phase_in = PH_SUM1;
               end else if (at_max) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_SUM1: phase_in = PH_SUM2;
            PH_SUM2: phase_in = PH_HUNT;
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   always_comb begin
      count_in    = count_ff;
      tail_hex_in = tail_hex_ff;
      first_o_in  = first_o_ff;
      bank_in     = bank_ff;
      q_push      = 1'b0;
      q_cmd       = '{mode: MODE_ACK_ONLY, ack: 1'b0, bank: bank_ff};
      ram_wr_en   = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == CHAR_START) begin
                  count_in    = '0;
                  tail_hex_in = 1'b1;
               end
            end
            PH_BODY: begin
               if (req_rx_byte == CHAR_END) begin
                  count_in = count_ff;
               end else if (at_max) begin
                  q_push      = 1'b1;
                  q_cmd.mode  = MODE_OVERFLOW;
                  count_in    = '0;
                  tail_hex_in = 1'b1;
               end else begin
                  if (count_ff != '0 && !is_hex(req_rx_byte)) begin
                     tail_hex_in = 1'b0;
                  end
                  if (count_ff == '0) begin
                     first_o_in = req_rx_byte == CHAR_CONSOLE;
                  end
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CNTW'(1);
               end
            end
            PH_SUM1: begin
               count_in = count_ff;
            end
            PH_SUM2: begin
               q_cmd.ack = ack_en_ff;
               if (is_console) begin
                  q_cmd.mode = MODE_ACK_ONLY;
               end else if (count_ff == '0) begin
                  q_cmd.mode = MODE_EMPTY;
               end else begin
                  q_cmd.mode = MODE_DATA;
                  bank_in    = ~bank_ff;
               end
               q_push      = ack_en_ff || !is_console;
               count_in    = '0;
               tail_hex_in = 1'b1;
            end
            default: count_in = count_ff;
         endcase
      end
   end

   assign q_count     = count_ff;
   assign ram_wr_addr = {bank_ff, count_ff[IDXW-1:0]};
   assign ram_wr_data = req_rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         count_ff    <= '0;
         tail_hex_ff <= 1'b1;
         first_o_ff  <= 1'b0;
         bank_ff     <= 1'b0;
         ack_en_ff   <= 1'b1;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         tail_hex_ff <= tail_hex_in;
         first_o_ff  <= first_o_in;
         bank_ff     <= bank_in;
         if (csr_wr_en) begin
            ack_en_ff <= csr_wr_data;
         end
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_PAYLOAD))
      else $error("payload count beyond maximum");
   a_overflow_in_body: assert property (@(posedge clock) disable iff (reset)
      q_push && q_cmd.mode == MODE_OVERFLOW |=> phase_ff == PH_HUNT && count_ff == '0)
      else $error("overflow did not return to hunting");
   a_data_flips_bank: assert property (@(posedge clock) disable iff (reset)
      q_push && q_cmd.mode == MODE_DATA |=> bank_ff != $past(bank_ff))
      else $error("payload bank not swapped after data packet");
`endif

endmodule

@@ sv/dpd_back.sv @@
// Result back end: turns queued packet commands into result transactions.
module dpd_back import dpd_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
   localparam int CNTW = $clog2(MAX_PAYLOAD + 1),
   localparam int IDXW = $clog2(MAX_PAYLOAD)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  cmd_type         q_cmd,
   input  logic [CNTW-1:0] q_count,
   output logic            q_pop,
   output logic            ram_rd_en,
   output logic [IDXW:0]   ram_rd_addr,
   input  logic [7:0]      ram_rd_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [1:0]      rsp_result_kind,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_last
);

   back_state_type  state_ff, state_in;
   logic [IDXW-1:0] idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   kind_type        kind_ff, emit_kind;
   logic [7:0]      data_ff, emit_data;
   logic            last_ff, emit_last;
   logic            emit;
   logic            out_free;
   logic            run_last;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign run_last = CNTW'(idx_ff) + CNTW'(1) == q_count;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               if (q_cmd.ack) begin
                  state_in = BK_ACK;
               end else if (q_cmd.mode == MODE_DATA) begin
                  state_in = BK_READ;
               end else begin
                  state_in = BK_TAIL;
               end
            end
         end
         BK_ACK: begin
            if (out_free) begin
               unique case (q_cmd.mode)
                  MODE_ACK_ONLY: state_in = BK_IDLE;
                  MODE_DATA:     state_in = BK_READ;
                  default:       state_in = BK_TAIL;
               endcase
            end
         end
         BK_READ: state_in = BK_DATA;
         BK_DATA: begin
            if (out_free) begin
               state_in = run_last ? BK_IDLE : BK_READ;
            end
         end
         BK_TAIL: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      emit      = 1'b0;
      emit_kind = KIND_ACK;
      emit_data = 8'h00;
      emit_last = 1'b0;
      q_pop     = 1'b0;
      ram_rd_en = 1'b0;
      idx_in    = idx_ff;
      unique case (state_ff)
         BK_IDLE: idx_in = '0;
         BK_ACK: begin
            emit      = out_free;
            emit_kind = KIND_ACK;
            emit_data = CHAR_ACK;
            emit_last = q_cmd.mode == MODE_ACK_ONLY;
            q_pop     = out_free && q_cmd.mode == MODE_ACK_ONLY;
         end
         BK_READ: ram_rd_en = 1'b1;
         BK_DATA: begin
            emit      = out_free;
            emit_kind = KIND_DATA;
            emit_data = ram_rd_data;
            emit_last = run_last;
            q_pop     = out_free && run_last;
            if (out_free) begin
               idx_in = idx_ff + IDXW'(1);
            end
         end
         BK_TAIL: begin
            emit      = out_free;
            emit_kind = (q_cmd.mode == MODE_OVERFLOW) ? KIND_OVERFLOW : KIND_EMPTY;
            emit_last = 1'b1;
            q_pop     = out_free;
         end
         default: idx_in = '0;
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   assign ram_rd_addr = {q_cmd.bank, idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= emit_kind;
         data_ff <= emit_data;
         last_ff <= emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_data_byte   = data_ff;
   assign rsp_last        = last_ff;

`ifndef SYNTH
   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command retired with an empty queue");
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_DATA |-> CNTW'(idx_ff) < q_count)
      else $error("payload read beyond packet length");
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      emit |-> q_pop == emit_last)
      else $error("command retired out of step with the last result");
   a_idle_after_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == BK_IDLE)
      else $error("back end busy after retiring a command");
`endif

endmodule

@@ sv/debug_packet_deframer_unit.sv @@
// Top level of the debug packet deframer.
//
// The req_ channel carries one received link byte per transaction. The front
// end hunts for '$', stores payload bytes up to '#', skips two checksum
// characters and queues at most one command per finished packet (or per overflow).
// The rsp_ channel carries the results: an optional '+' acknowledge, then the
// payload bytes, an empty-reply marker or an overflow error; rsp_last marks
// the final result of the byte that caused them. Console packets ('O' plus
// hex digits) give only the acknowledge, and nothing while it is disabled.
// Input bytes are taken one per cycle while the two-entry command queue has
// room. The first result of a byte passes through the command queue, the
// back-end state register and the result register; the back end reads
// each payload byte from the registered payload RAM and outputs it before
// it reads the next. The payload RAM holds two packets, so a new packet is
// received while the previous one drains.
// csr_wr_en/csr_wr_data set the acknowledge enable. Reset returns to
// hunting, empties the queue and sets the acknowledge enable. When the
// receiver stalls, the result register holds and the queue fills, after
// which req_ready drops.
module debug_packet_deframer_unit import dpd_pkg::*; #(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   localparam int CNTW  = $clog2(MAX_PAYLOAD + 1);
   localparam int IDXW  = $clog2(MAX_PAYLOAD);
   localparam int QW    = $bits(cmd_type) + CNTW;
   localparam int DEPTH = 2 ** (IDXW + 1);

   logic            q_full, q_empty, q_push, q_pop;
   cmd_type         push_cmd, head_cmd;
   logic [CNTW-1:0] push_count, head_count;
   logic [QW-1:0]   head_word;
   logic            ram_wr_en, ram_rd_en;
   logic [IDXW:0]   ram_wr_addr, ram_rd_addr;
   logic [7:0]      ram_wr_data, ram_rd_data;

   dpd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd),
      .q_count     (push_count),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   dpd_cmd_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_cmd, push_count}),
      .pop       (q_pop),
      .head_data (head_word),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign head_cmd   = cmd_type'(head_word[QW-1:CNTW]);
   assign head_count = head_word[CNTW-1:0];

   dpd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dpd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_cmd           (head_cmd),
      .q_count         (head_count),
      .q_pop           (q_pop),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_last        (rsp_last)
   );

endmodule

@@ test/deframer_checker.sv @@
// Result predictor and scoreboard for the debug packet deframer.
module deframer_checker import dpd_pkg::*; #(
   parameter int PAYLOAD_MAX = MAX_PAYLOAD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_result_kind,
   input  logic [7:0] rsp_data_byte,
   input  logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   output int         fail_count,
   output int         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } result_type;

   result_type expected_q[$];
   result_type staged [PAYLOAD_MAX + 1];
   int         staged_n;
   result_type want;

   phase_type  rx_phase = PH_HUNT;
   logic [7:0] payload_mem [PAYLOAD_MAX];
   int         payload_len = 0;
   bit         tail_hex = 1'b1;
   bit         ack_on = 1'b1;
   int         errors = 0;

   function automatic bit hex_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   task automatic stage(input kind_type k, input logic [7:0] d);
      staged[staged_n] = '{kind: k, data: d, last: 1'b0};
      staged_n++;
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      staged_n = 0;
      case (rx_phase)
         PH_HUNT: begin
            if (b == CHAR_START) begin
               payload_len = 0;
               tail_hex = 1'b1;
               rx_phase = PH_BODY;
            end
         end
         PH_BODY: begin
            if (b == CHAR_END) begin
               rx_phase = PH_SUM1;
            end else if (payload_len >= PAYLOAD_MAX) begin
               stage(KIND_OVERFLOW, 8'h00);
               payload_len = 0;
               tail_hex = 1'b1;
               rx_phase = PH_HUNT;
            end else begin
               if (payload_len >= 1 && !hex_char(b))
                  tail_hex = 1'b0;
               payload_mem[payload_len] = b;
               payload_len++;
            end
         end
         PH_SUM1: rx_phase = PH_SUM2;
         default: begin
            rx_phase = PH_HUNT;
            if (ack_on)
               stage(KIND_ACK, CHAR_ACK);
            // drop console packets
            if (!(payload_len > 1 && payload_mem[0] == CHAR_CONSOLE && tail_hex)) begin
               if (payload_len == 0)
                  stage(KIND_EMPTY, 8'h00);
               else
                  for (int i = 0; i < payload_len; i++)
                     stage(KIND_DATA, payload_mem[i]);
            end
            payload_len = 0;
            tail_hex = 1'b1;
         end
      endcase
      if (staged_n > 0)
         staged[staged_n - 1].last = 1'b1;
      for (int i = 0; i < staged_n; i++)
         expected_q.push_back(staged[i]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rx_phase = PH_HUNT;
         payload_len = 0;
         tail_hex = 1'b1;
         ack_on = 1'b1;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: kind %0d data %02h last %0b",
                           rsp_result_kind, rsp_data_byte, rsp_last);
            end else begin
               want = expected_q.pop_front();
               if (rsp_result_kind !== want.kind || rsp_data_byte !== want.data ||
                   rsp_last !== want.last) begin
                  errors++;
                  if (errors <= 10)
                     $display({"result mismatch: expected kind %0d data %02h last %0b,",
                               " got kind %0d data %02h last %0b"},
                              want.kind, want.data, want.last,
                              rsp_result_kind, rsp_data_byte, rsp_last);
               end
            end
         end
         if (csr_wr_en)
            ack_on = csr_wr_data;
         if (req_valid && req_ready)
            deframe_byte(req_rx_byte);
      end
      fail_count <= errors;
      outstanding <= expected_q.size();
   end

endmodule

@@ test/testbench.sv @@
// Stimulus, clocking and final verdict for the debug packet deframer.
module testbench import dpd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 16;
   localparam int RESET_CYCLES    = 8;
   localparam int ITEMS_PER_PHASE = 90;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_data_byte;
   logic       rsp_last;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   int fail_count;
   int outstanding;
   int send_idle_pct = 33;
   int recv_idle_pct = 58;
   int items_left = 0;
   int quiet_cycles = 0;

   debug_packet_deframer_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   deframer_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[debug_packet_deframer_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] any_body_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == CHAR_END);
      return b;
   endfunction

   function automatic logic [7:0] random_hex();
      int r;
      r = $urandom_range(21);
      if (r < 10)
         return 8'(32'h30 + r);
      else if (r < 16)
         return 8'(32'h61 + r - 10);
      else
         return 8'(32'h41 + r - 16);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      items_left--;
   endtask

   task automatic close_packet();
      send_byte(CHAR_END);
      send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ack_enable(input logic value);
      drain_and_settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_packet(input int roll);
      int len;
      int bad_pos;
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
      send_byte(CHAR_START);
      if (roll < 6) begin
         repeat (MAX_PAYLOAD_DEF) send_byte(any_body_byte());
         close_packet();
      end else if (roll < 11) begin
         repeat (MAX_PAYLOAD_DEF + $urandom_range(3, 1)) send_byte(any_body_byte());
      end else if (roll < 35) begin
         len = $urandom_range(6, 1);
         bad_pos = ($urandom_range(3) == 0) ? $urandom_range(len, 1) : 0;
         send_byte(CHAR_CONSOLE);
         for (int i = 1; i <= len; i++)
            send_byte((i == bad_pos) ? any_body_byte() : random_hex());
         close_packet();
      end else if (roll < 90) begin
         len = (roll < 45) ? $urandom_range(1) : $urandom_range(8, 1);
         repeat (len) send_byte(any_body_byte());
         close_packet();
      end else begin
         repeat ($urandom_range(4)) send_byte(any_body_byte());
      end
   endtask

   task automatic random_phase(input int first_roll);
      items_left = ITEMS_PER_PHASE;
      random_packet(first_roll);
      while (items_left > 0) random_packet($urandom_range(99));
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ignored while hunting
      send_byte(CHAR_END);
      send_byte(8'h00);
      send_byte(CHAR_START);
      close_packet();
      send_byte(CHAR_START);
      send_byte(8'h00);
      send_byte(CHAR_START);
      send_byte(8'hff);
      close_packet();
      send_byte(CHAR_START);
      send_byte(CHAR_CONSOLE);
      send_byte(8'h30);
      send_byte(8'h66);
      close_packet();

      write_ack_enable(1'b0);
      send_byte(CHAR_START);
      send_byte(CHAR_CONSOLE);
      send_byte(8'h41);
      close_packet();
      send_byte(CHAR_START);
      close_packet();

      write_ack_enable(1'b1);
      random_phase(0);

      write_ack_enable(1'b0);
      send_idle_pct = 58;
      recv_idle_pct = 33;
      random_phase(8);

      write_ack_enable(1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase($urandom_range(99));

      drain_and_settle();
      if (fail_count == 0 && outstanding == 0)
         $display("[debug_packet_deframer_unit] OK");
      else
         $display("[debug_packet_deframer_unit] ERROR");
      $finish;
   end

endmodule
